FILE: hw/rtl/dns_query_parser_top_macros.svh
// Assertion macros for the DNS query parser checker.
// Expects clk and rst_n in the scope of use.
`ifndef DNS_QUERY_PARSER_TOP_MACROS_SVH
`define DNS_QUERY_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define DQP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dqp check failed");

// next-cycle implication
`define DQP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dqp check failed");

`endif

FILE: hw/rtl/dqp_pkg.sv
// Shared types and constants for the DNS query parser.
// No dependencies.
`default_nettype none

package dqp_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_CHAR,
        KIND_QEND,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_SHORT,
        ERR_ANSWERS,
        ERR_NAME_LONG,
        ERR_TRUNC
    } err_t;

    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_packet;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  name_char;
        logic [15:0] msg_id;
        logic        qr_bit;
        logic [3:0]  op_code;
        logic [3:0]  flag_bits;
        logic [3:0]  resp_code;
        logic [15:0] question_count;
        logic [15:0] query_type;
        logic [15:0] query_class;
        err_t        error_code;
        logic        last;
    } result_t;

    typedef struct packed {
        result_t res;
        logic    tail_trunc;
    } entry_t;

    typedef struct packed {
        logic   empty;
        entry_t head;
    } q_rd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dqp_front.sv
// Front part: takes packet bytes, tracks header and question phases,
// classifies bytes into queue entries. Depends on dqp_pkg.
`default_nettype none

module dqp_front #(
    parameter int NAME_LIMIT = 256
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            take,
    input  dqp_pkg::item_t item,
    output logic           wr_en,
    output dqp_pkg::entry_t wr_entry
);
    import dqp_pkg::*;

    localparam int NLW = $clog2(NAME_LIMIT - 1);
    localparam logic [3:0] POS_ID_END  = 4'd6;
    localparam logic [3:0] POS_CNT_END = 4'd10;
    localparam logic [3:0] POS_HDR_END = 4'd11;
    localparam logic [3:0] POS_TC_END  = 4'd3;
    localparam logic [7:0] CH_DOT      = 8'h2E;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_NAME,
        PH_TYPECLASS
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    logic [47:0]      hs_reg, hs_next;
    logic             ans_reg, ans_next;
    logic [15:0]      ql_reg, ql_next;
    logic [NLW-1:0]   nl_reg, nl_next;
    logic [23:0]      tc_reg, tc_next;
    logic             disc_reg, disc_next;
    logic             produce;
    logic             tail;
    result_t          res;
    logic [7:0]       b;
    logic [15:0]      fl;

    assign b  = item.in_byte;
    assign fl = hs_reg[31:16];

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hs_next    = hs_reg;
        ans_next   = ans_reg;
        ql_next    = ql_reg;
        nl_next    = nl_reg;
        tc_next    = tc_reg;
        disc_next  = disc_reg;
        produce    = 1'b0;
        tail       = 1'b0;
        res        = '0;
        if (take)
        begin
            if (disc_reg)
            begin
                if (item.end_of_packet)
                begin
                    phase_next = PH_HEADER;
                    pos_next   = '0;
                    ans_next   = 1'b0;
                    disc_next  = 1'b0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (pos_reg < POS_ID_END)
                            hs_next = {hs_reg[39:0], b};
                        else if (pos_reg < POS_CNT_END && b != 8'd0)
                            ans_next = 1'b1;
                        if (pos_reg == POS_HDR_END)
                        begin
                            pos_next = '0;
                            produce  = 1'b1;
                            if (ans_reg)
                            begin
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_ANSWERS;
                                res.last       = 1'b1;
                                disc_next      = 1'b1;
                            end
                            else
                            begin
                                res.kind           = KIND_HEADER;
                                res.msg_id         = hs_reg[47:32];
                                res.qr_bit         = fl[15];
                                res.op_code        = fl[14:11];
                                res.flag_bits      = fl[10:7];
                                res.resp_code      = fl[3:0];
                                res.question_count = hs_reg[15:0];
                                ql_next            = hs_reg[15:0];
                                if (hs_reg[15:0] == 16'd0)
                                begin
                                    res.last  = 1'b1;
                                    disc_next = 1'b1;
                                end
                                else
                                    phase_next = PH_LENGTH;
                            end
                        end
                        else
                            pos_next = pos_reg + 4'd1;
                    end
                    PH_LENGTH:
                    begin
                        phase_next = PH_NAME;
                        nl_next    = '0;
                    end
                    PH_NAME:
                    begin
                        if (b == 8'd0)
                        begin
                            phase_next = PH_TYPECLASS;
                            pos_next   = '0;
                        end
                        else if (nl_reg >= NLW'(NAME_LIMIT - 2))
                        begin
                            produce        = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NAME_LONG;
                            res.last       = 1'b1;
                            disc_next      = 1'b1;
                        end
                        else
                        begin
                            produce  = 1'b1;
                            res.kind = KIND_CHAR;
                            if (b inside {[8'h61:8'h7A], [8'h30:8'h39], 8'h2D})
                                res.name_char = b;
                            else
                                res.name_char = CH_DOT;
                            nl_next = nl_reg + NLW'(1);
                        end
                    end
                    PH_TYPECLASS:
                    begin
                        if (pos_reg == POS_TC_END)
                        begin
                            pos_next        = '0;
                            produce         = 1'b1;
                            res.kind        = KIND_QEND;
                            res.query_type  = tc_reg[23:8];
                            res.query_class = {tc_reg[7:0], b};
                            ql_next         = ql_reg - 16'd1;
                            if (ql_reg == 16'd1)
                            begin
                                res.last  = 1'b1;
                                disc_next = 1'b1;
                            end
                            else
                                phase_next = PH_LENGTH;
                        end
                        else
                        begin
                            tc_next  = {tc_reg[15:0], b};
                            pos_next = pos_reg + 4'd1;
                        end
                    end
                    default:
                        phase_next = PH_HEADER;
                endcase
                if (item.end_of_packet)
                begin
                    if (!disc_next)
                    begin
                        if (produce)
                            tail = 1'b1;
                        else
                        begin
                            produce        = 1'b1;
                            res            = '0;
                            res.kind       = KIND_ERROR;
                            res.error_code = (phase_next == PH_HEADER) ? ERR_SHORT : ERR_TRUNC;
                            res.last       = 1'b1;
                        end
                    end
                    phase_next = PH_HEADER;
                    pos_next   = '0;
                    ans_next   = 1'b0;
                    disc_next  = 1'b0;
                end
            end
        end
    end

    assign wr_en    = produce;
    assign wr_entry = '{res: res, tail_trunc: tail};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            ans_reg   <= 1'b0;
            disc_reg  <= 1'b0;
            hs_reg    <= '0;
            ql_reg    <= '0;
            nl_reg    <= '0;
            tc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ans_reg   <= ans_next;
            disc_reg  <= disc_next;
            hs_reg    <= hs_next;
            ql_reg    <= ql_next;
            nl_reg    <= nl_next;
            tc_reg    <= tc_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dqp_queue.sv
// Short queue of classified entries between front and back parts.
// Depends on dqp_pkg.
`default_nettype none

module dqp_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             wr_en,
    input  dqp_pkg::entry_t wr_entry,
    input  wire             rd_en,
    output dqp_pkg::q_rd_t  rd,
    output logic            q_full
);
    import dqp_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    entry_t         mem_reg [QDEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [PW:0]    cnt_reg;
    logic           do_wr, do_rd;

    assign do_wr    = wr_en && (cnt_reg != (PW+1)'(QDEPTH));
    assign do_rd    = rd_en && (cnt_reg != '0);
    assign q_full   = (cnt_reg == (PW+1)'(QDEPTH));
    assign rd.empty = (cnt_reg == '0);
    assign rd.head  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + PW'(1);
            if (do_rd)
                rp_reg <= rp_reg + PW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + (PW+1)'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - (PW+1)'(1);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dqp_back.sv
// Back part: expands queue entries into result beats and holds the
// oldest beat in an output register. Depends on dqp_pkg.
`default_nettype none

module dqp_back (
    input  wire              clk,
    input  wire              rst_n,
    input  dqp_pkg::q_rd_t   rd,
    output logic             rd_en,
    input  wire              pop,
    output logic             empty,
    output dqp_pkg::result_t result
);
    import dqp_pkg::*;

    result_t out_reg, out_next;
    logic    vld_reg, vld_next;
    logic    half_reg, half_next;
    result_t trunc_res;
    logic    load;

    always_comb
    begin
        trunc_res            = '0;
        trunc_res.kind       = KIND_ERROR;
        trunc_res.error_code = ERR_TRUNC;
        trunc_res.last       = 1'b1;
    end

    assign load = !vld_reg || pop;

    always_comb
    begin
        out_next  = out_reg;
        vld_next  = vld_reg && !pop;
        half_next = half_reg;
        rd_en     = 1'b0;
        if (load && !rd.empty)
        begin
            vld_next = 1'b1;
            if (half_reg)
            begin
                out_next  = trunc_res;
                half_next = 1'b0;
                rd_en     = 1'b1;
            end
            else
            begin
                out_next = rd.head.res;
                if (rd.head.tail_trunc)
                    half_next = 1'b1;
                else
                    rd_en = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            half_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            half_reg <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty  = !vld_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/dns_query_parser_top.sv
// DNS query parser top level: front classifier, entry queue, back expander.
// Depends on dqp_pkg, dqp_front, dqp_queue, dqp_back.
//
// One packet byte is accepted per cycle, every cycle, as long as full is low;
// end_of_packet on a byte closes the packet and the next byte starts a new
// header. Results come out one per cycle while pop is high, each passing
// through the entry queue and the output register. A byte that gives a result
// and is also the last of a truncated packet gives two results, sent in turn
// from one queue entry. full rises only when the four-entry queue between the
// front and back parts is full, which happens when pop is held low or results
// queue behind such a double result. Names longer than NAME_LIMIT-2 characters
// are reported as an error and the rest of the packet is dropped.
`default_nettype none

module dns_query_parser_top #(
    parameter int NAME_LIMIT = 256
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    output logic             full,
    input  dqp_pkg::item_t   item,
    output logic             empty,
    input  wire              pop,
    output dqp_pkg::result_t result
);
    import dqp_pkg::*;

    logic   take;
    logic   wr_en;
    entry_t wr_entry;
    logic   rd_en;
    q_rd_t  rd;
    logic   q_full;

    assign full = q_full;
    assign take = push && !q_full;

    dqp_front #(
        .NAME_LIMIT(NAME_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .wr_en    (wr_en),
        .wr_entry (wr_entry)
    );

    dqp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd       (rd),
        .q_full   (q_full)
    );

    dqp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (rd),
        .rd_en  (rd_en),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/dqp_checker.sv
// Port-level checks for dns_query_parser_top, attached by bind.
// Depends on dqp_pkg and dns_query_parser_top_macros.svh.
`default_nettype none

`include "dns_query_parser_top_macros.svh"

module dqp_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              empty,
    input wire              pop,
    input dqp_pkg::result_t result
);
    import dqp_pkg::*;

    `DQP_ASSERT_NEXT(a_hold_beat, !empty && !pop, !empty && $stable(result))
    `DQP_ASSERT_NOW(a_error_last, !empty && result.kind == KIND_ERROR, result.last)
    `DQP_ASSERT_NOW(a_char_not_last, !empty && result.kind == KIND_CHAR, !result.last)
    `DQP_ASSERT_NOW(a_noq_last,
        !empty && result.kind == KIND_HEADER && result.question_count == 16'd0, result.last)

endmodule

bind dns_query_parser_top dqp_checker u_dqp_checker (.*);

`default_nettype wire

FILE: tb/dns_query_parser_top_tb.sv
// Self-checking testbench for dns_query_parser_top: byte stream in, decoded records out.
// Depends on dqp_pkg and dns_query_parser_top; a built-in decoder predicts every record.
// Directed packets first, then random well-formed, corrupted and truncated packets.
`default_nettype none

module dns_query_parser_top_tb;
    import dqp_pkg::*;

    localparam int NAME_LIMIT = 256;
    localparam int TOTAL_BEATS = 1500;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_CYCLES = 600000;

    typedef enum logic [1:0] {
        P_HEADER,
        P_LENGTH,
        P_NAME,
        P_TYPECLASS
    } parse_phase_t;

    typedef struct {
        item_t       beat;
        int unsigned gap;
        bit          drain;
        bit          hold;
    } beat_plan_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    full;
    item_t   item = '0;
    logic    empty;
    logic    pop = 1'b0;
    result_t result;

    parse_phase_t ph = P_HEADER;
    logic [3:0]   pos = '0;
    logic [63:0]  hdr = '0;
    logic [15:0]  q_left = '0;
    logic [7:0]   name_len = '0;
    logic [31:0]  tc_shift = '0;
    logic         dropping = 1'b0;

    result_t    records_due[$];
    beat_plan_t packet_beats[$];
    logic [7:0] pkt[$];
    beat_plan_t plan;

    int fails = 0;
    int beats_queued = 0;
    int beats_taken = 0;
    int tx_seen = 0;
    bit tx_busy = 1'b0;
    int unsigned gap_left = 0;
    bit hold_asked = 1'b0;
    bit hold_started = 1'b0;
    int hold_left = 0;
    int rx_taken = 0;
    int rx_seen = 0;
    int unsigned rx_drawn = 0;
    int unsigned rx_left = 0;
    bit rx_calm = 1'b0;
    int cycle_count = 0;

    dns_query_parser_top #(
        .NAME_LIMIT(NAME_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic restart_decoder();
        ph = P_HEADER;
        pos = '0;
        hdr = '0;
        q_left = '0;
        name_len = '0;
        tc_shift = '0;
        dropping = 1'b0;
    endtask

    task automatic note_error(input err_t code);
        result_t rec;
        rec = '0;
        rec.kind = KIND_ERROR;
        rec.error_code = code;
        rec.last = 1'b1;
        records_due.push_back(rec);
    endtask

    task automatic decode_dns_byte(input logic [7:0] b, input logic eop);
        result_t rec;
        int base;
        base = records_due.size();
        if (dropping)
        begin
            if (eop)
                restart_decoder();
            return;
        end
        case (ph)
            P_HEADER:
            begin
                if (pos < 6)
                    hdr = {16'h0000, hdr[39:0], b};
                else if (pos < 10 && b != 8'h00)
                    hdr[48] = 1'b1;
                pos = pos + 4'd1;
                if (pos >= 12)
                begin
                    pos = '0;
                    if (hdr[48])
                    begin
                        note_error(ERR_ANSWERS);
                        dropping = 1'b1;
                    end
                    else
                    begin
                        rec = '0;
                        rec.kind = KIND_HEADER;
                        rec.msg_id = hdr[47:32];
                        rec.qr_bit = hdr[31];
                        rec.op_code = hdr[30:27];
                        rec.flag_bits = hdr[26:23];
                        rec.resp_code = hdr[19:16];
                        rec.question_count = hdr[15:0];
                        q_left = hdr[15:0];
                        if (q_left == 16'h0000)
                        begin
                            rec.last = 1'b1;
                            dropping = 1'b1;
                        end
                        else
                            ph = P_LENGTH;
                        records_due.push_back(rec);
                    end
                end
            end
            P_LENGTH:
            begin
                ph = P_NAME;
                name_len = '0;
            end
            P_NAME:
            begin
                if (b == 8'h00)
                begin
                    ph = P_TYPECLASS;
                    pos = '0;
                    tc_shift = '0;
                end
                else if (int'(name_len) >= NAME_LIMIT - 2)
                begin
                    note_error(ERR_NAME_LONG);
                    dropping = 1'b1;
                end
                else
                begin
                    rec = '0;
                    rec.kind = KIND_CHAR;
                    if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h30 && b <= 8'h39) || b == 8'h2D)
                        rec.name_char = b;
                    else
                        rec.name_char = 8'h2E;
                    name_len = name_len + 8'd1;
                    records_due.push_back(rec);
                end
            end
            default:
            begin
                tc_shift = {tc_shift[23:0], b};
                pos = pos + 4'd1;
                if (pos >= 4)
                begin
                    pos = '0;
                    rec = '0;
                    rec.kind = KIND_QEND;
                    rec.query_type = tc_shift[31:16];
                    rec.query_class = tc_shift[15:0];
                    q_left = q_left - 16'd1;
                    if (q_left == 16'h0000)
                    begin
                        rec.last = 1'b1;
                        dropping = 1'b1;
                    end
                    else
                        ph = P_LENGTH;
                    records_due.push_back(rec);
                end
            end
        endcase
        if (eop)
        begin
            if (!dropping && records_due.size() - base < 2)
                note_error(ph == P_HEADER ? ERR_SHORT : ERR_TRUNC);
            restart_decoder();
        end
    endtask

    task automatic check_record(input result_t want, input result_t got);
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fails++;
        end
        if (got.name_char !== want.name_char)
        begin
            $error("name_char: expected %0h, got %0h", want.name_char, got.name_char);
            fails++;
        end
        if (got.msg_id !== want.msg_id)
        begin
            $error("msg_id: expected %0h, got %0h", want.msg_id, got.msg_id);
            fails++;
        end
        if (got.qr_bit !== want.qr_bit)
        begin
            $error("qr_bit: expected %0d, got %0d", want.qr_bit, got.qr_bit);
            fails++;
        end
        if (got.op_code !== want.op_code)
        begin
            $error("op_code: expected %0h, got %0h", want.op_code, got.op_code);
            fails++;
        end
        if (got.flag_bits !== want.flag_bits)
        begin
            $error("flag_bits: expected %0h, got %0h", want.flag_bits, got.flag_bits);
            fails++;
        end
        if (got.resp_code !== want.resp_code)
        begin
            $error("resp_code: expected %0h, got %0h", want.resp_code, got.resp_code);
            fails++;
        end
        if (got.question_count !== want.question_count)
        begin
            $error("question_count: expected %0h, got %0h",
                   want.question_count, got.question_count);
            fails++;
        end
        if (got.query_type !== want.query_type)
        begin
            $error("query_type: expected %0h, got %0h", want.query_type, got.query_type);
            fails++;
        end
        if (got.query_class !== want.query_class)
        begin
            $error("query_class: expected %0h, got %0h", want.query_class, got.query_class);
            fails++;
        end
        if (got.error_code !== want.error_code)
        begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            fails++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                decode_dns_byte(item.in_byte, item.end_of_packet);
                beats_taken++;
            end
            if (pop && !empty)
            begin
                if (records_due.size() == 0)
                begin
                    $error("kind: expected none, got %0d", result.kind);
                    fails++;
                end
                else
                    check_record(records_due.pop_front(), result);
                rx_taken++;
                if (rx_taken % 48 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_drawn = rx_calm ? 0 : $urandom_range(0, 18);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_asked && !hold_started)
        begin
            hold_left <= HOLD_CYCLES;
            hold_started <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (tx_seen != beats_taken)
        begin
            tx_seen = beats_taken;
            tx_busy = 1'b0;
            gap_left = (packet_beats.size() != 0) ? packet_beats[0].gap : 0;
        end
        if (rst_n && !tx_busy)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (packet_beats.size() != 0 &&
                     !(packet_beats[0].drain && records_due.size() != 0))
            begin
                plan = packet_beats.pop_front();
                item <= plan.beat;
                push <= 1'b1;
                tx_busy = 1'b1;
                if (plan.hold)
                    hold_asked = 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rx_seen != rx_taken)
        begin
            rx_seen = rx_taken;
            rx_left = rx_drawn;
        end
        if (!rst_n || hold_left != 0)
            pop <= 1'b0;
        else if (rx_left != 0)
        begin
            rx_left--;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(8'h61, 8'h7A));
            4, 5: return 8'($urandom_range(8'h30, 8'h39));
            6: return 8'h2D;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic put_header(input logic [15:0] id, input logic [15:0] fl,
                              input logic [15:0] qd, input logic [15:0] an,
                              input logic [15:0] ns, input logic [15:0] ar);
        logic [95:0] words;
        words = {id, fl, qd, an, ns, ar};
        for (int i = 11; i >= 0; i--)
            pkt.push_back(words[i*8 +: 8]);
    endtask

    task automatic put_name(input string s);
        for (int i = 0; i < s.len(); i++)
            pkt.push_back(s[i]);
    endtask

    task automatic put_random_name(input int count);
        repeat (count)
            pkt.push_back(pick_char());
    endtask

    task automatic end_question(input logic [31:0] tc);
        pkt.push_back(8'h00);
        for (int i = 3; i >= 0; i--)
            pkt.push_back(tc[i*8 +: 8]);
    endtask

    task automatic ship_packet(input bit drain, input bit hold);
        beat_plan_t p;
        bit calm;
        calm = hold || ($urandom_range(0, 3) == 0);
        foreach (pkt[i])
        begin
            p.beat.in_byte = pkt[i];
            p.beat.end_of_packet = (i == pkt.size() - 1);
            p.gap = calm ? 0 : $urandom_range(0, 18);
            p.drain = drain && i == 0;
            p.hold = hold && i == 0;
            packet_beats.push_back(p);
        end
        beats_queued += pkt.size();
        pkt.delete();
    endtask

    task automatic random_packet();
        int shape;
        int nq;
        int nlen;
        int keep;
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] ns;
        shape = $urandom_range(0, 99);
        nq = $urandom_range(1, 3);
        qd = 16'(nq);
        an = '0;
        ns = '0;
        if (shape < 4)
            qd = '0;
        else if (shape < 8)
            qd = 16'($urandom_range(1, 65535));
        else if (shape < 14)
        begin
            an = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 65535)) : 16'h0000;
            ns = (an == 16'h0000) ? 16'($urandom_range(1, 65535))
                                  : 16'($urandom_range(0, 65535));
        end
        put_header(16'($urandom()), 16'($urandom()), qd, an, ns, 16'($urandom()));
        for (int i = 0; i < nq; i++)
        begin
            pkt.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 63)));
            nlen = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 262)
                                                : $urandom_range(0, 20);
            put_random_name(nlen);
            end_question($urandom());
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5))
                pkt.push_back(8'($urandom_range(0, 255)));
        if (shape >= 14 && shape < 26)
        begin
            keep = $urandom_range(1, pkt.size());
            while (pkt.size() > keep)
                void'(pkt.pop_back());
        end
    endtask

    initial
    begin
        int pkt_no;

        // lone byte, then a header one byte short
        pkt.push_back(8'hFF);
        ship_packet(1'b0, 1'b0);
        put_header(16'h1234, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        void'(pkt.pop_back());
        ship_packet(1'b0, 1'b0);

        put_header(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
        pkt.push_back(8'h55);
        ship_packet(1'b0, 1'b0);
        put_header(16'h0000, 16'h0000, 16'h0002, 16'h0000, 16'h0100, 16'hFFFF);
        ship_packet(1'b0, 1'b0);

        put_header(16'hABCD, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0003);
        pkt.push_back(8'h07);
        ship_packet(1'b0, 1'b0);

        // header and truncation on the same beat
        put_header(16'h0001, 16'h8000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        ship_packet(1'b1, 1'b0);

        put_header(16'h00FF, 16'h7F8F, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        pkt.push_back(8'h00);
        put_name("az09-AZ.~");
        pkt.push_back(8'hFF);
        pkt.push_back(8'h01);
        end_question(32'h0001_0001);
        pkt.push_back(8'h00);
        ship_packet(1'b0, 1'b0);

        put_header(16'h5A5A, 16'h0100, 16'h0002, 16'h0000, 16'h0000, 16'h0000);
        pkt.push_back(8'h03);
        put_name("www");
        end_question(32'hFFFF_FFFF);
        pkt.push_back(8'h04);
        put_name("ab");
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'h1C);
        ship_packet(1'b0, 1'b0);

        put_header(16'h2222, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        pkt.push_back(8'h05);
        put_name("abc");
        ship_packet(1'b0, 1'b0);

        put_header(16'h3333, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        pkt.push_back(8'h01);
        ship_packet(1'b0, 1'b0);

        // longest accepted name, then a name far over the limit
        put_header(16'h4444, 16'h0180, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        pkt.push_back(8'hFF);
        put_random_name(NAME_LIMIT - 2);
        end_question(32'h00FF_00FE);
        ship_packet(1'b0, 1'b0);
        put_header(16'h5555, 16'h0000, 16'h0003, 16'h0000, 16'h0000, 16'h0000);
        pkt.push_back(8'h3F);
        put_random_name(300);
        end_question(32'h0001_0001);
        ship_packet(1'b0, 1'b0);

        pkt_no = 0;
        while (beats_queued < TOTAL_BEATS)
        begin
            pkt_no++;
            if (pkt_no == 5)
            begin
                put_header(16'($urandom()), 16'h0100, 16'h0001, 16'h0000, 16'h0000,
                           16'h0000);
                pkt.push_back(8'h28);
                put_random_name(40);
                end_question($urandom());
                ship_packet(1'b0, 1'b1);
            end
            random_packet();
            ship_packet(pkt_no % 25 == 0, 1'b0);
        end

        while (packet_beats.size() != 0 || tx_busy)
            @(posedge clk);
        while (records_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/dqp_pkg.sv
hw/rtl/dqp_front.sv
hw/rtl/dqp_queue.sv
hw/rtl/dqp_back.sv
hw/rtl/dns_query_parser_top.sv
hw/rtl/dqp_checker.sv
tb/dns_query_parser_top_tb.sv
